/* rtl/core/cpck_pkg.sv */
// shared types, constants and saturating arithmetic for the coulomb pair kernel
package cpck_pkg;

   typedef logic signed [47:0] q_type;

   localparam q_type Q_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam q_type Q_MIN = 48'sh8000_0000_0000;
   localparam q_type Q_ONE = 48'sh0001_0000_0000;

   localparam int MID_DEPTH  = 4;
   localparam int OUT_DEPTH  = 16;
   localparam int PIPE_DEPTH = 13;
   localparam int MUL_COUNT  = 16;

   typedef enum logic [2:0] {
      KIND_ZERO,
      KIND_UNSW,
      KIND_SH1,
      KIND_SH2,
      KIND_SW
   } kind_type;

   typedef enum logic [1:0] {
      NORM_NONE,
      NORM_SHIFT1,
      NORM_SHIFT2,
      NORM_SWITCH
   } norm_mode_type;

   typedef enum logic [2:0] {
      O14_NONE,
      O14_FULL,
      O14_SHIFT1,
      O14_SHIFT2,
      O14_SWITCH
   } o14_mode_type;

   typedef enum logic [2:0] {
      REG_PAIR_MODES,
      REG_CHARGE_CONSTANT,
      REG_SCALE_ONE_FOUR,
      REG_INV_CUTOFF,
      REG_INV_CUTOFF_SQ,
      REG_CUT_ON_SQ,
      REG_CUT_OFF_SQ,
      REG_SWITCH_NORM
   } reg_index_type;

   typedef struct packed {
      logic        is_one_four;
      q_type       charge_product;
      logic [46:0] dist_sq;
      logic [46:0] inv_dist;
   } req_word_type;

   typedef struct packed {
      q_type energy;
      q_type force_factor;
   } rsp_word_type;

   typedef struct packed {
      logic [4:0]  pair_modes;
      q_type       charge_constant;
      q_type       scale_one_four;
      logic [46:0] inv_cutoff;
      logic [46:0] inv_cutoff_sq;
      logic [46:0] cut_on_sq;
      logic [46:0] cut_off_sq;
      q_type       switch_norm;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic        one_four;
      q_type       q;
      logic [46:0] r2;
      logic [46:0] rt;
   } work_type;

   function automatic q_type q_ext(input logic [46:0] v);
      return q_type'({1'b0, v});
   endfunction

   function automatic q_type q_sat(input logic signed [55:0] v);
      q_type r;
      if (v > 56'(Q_MAX)) begin
         r = Q_MAX;
      end else if (v < 56'(Q_MIN)) begin
         r = Q_MIN;
      end else begin
         r = v[47:0];
      end
      return r;
   endfunction

   function automatic q_type q_add(input q_type a, input q_type b);
      return q_sat(56'(a) + 56'(b));
   endfunction

   function automatic q_type q_sub(input q_type a, input q_type b);
      return q_sat(56'(a) - 56'(b));
   endfunction

   function automatic q_type q_scale(input q_type a, input logic [3:0] k);
      return q_sat(56'(a) * $signed({52'b0, k}));
   endfunction

   function automatic q_type q_neg(input q_type a);
      return (a == Q_MIN) ? Q_MAX : -a;
   endfunction

endpackage

/* rtl/core/cpck_mul.sv */
// q16.32 multiplier: registered partial products, then sum, floor and saturate
module cpck_mul
   import cpck_pkg::*;
(
   input  logic  clock,
   input  q_type op_a,
   input  q_type op_b,
   output q_type prod
);

   logic signed [23:0] a_hi, b_hi;
   logic        [23:0] a_lo, b_lo;
   logic signed [47:0] hh_in, hh_ff;
   logic signed [48:0] hl_in, hl_ff, lh_in, lh_ff;
   logic        [47:0] ll_in, ll_ff;
   logic signed [95:0] full;
   logic signed [63:0] fl;

   assign a_hi = op_a[47:24];
   assign a_lo = op_a[23:0];
   assign b_hi = op_b[47:24];
   assign b_lo = op_b[23:0];

   assign hh_in = a_hi * b_hi;
   assign hl_in = a_hi * $signed({1'b0, b_lo});
   assign lh_in = $signed({1'b0, a_lo}) * b_hi;
   assign ll_in = a_lo * b_lo;

   always_ff @(posedge clock) begin
      hh_ff <= hh_in;
      hl_ff <= hl_in;
      lh_ff <= lh_in;
      ll_ff <= ll_in;
   end

   assign full = (96'(hh_ff) <<< 48) + (96'(hl_ff) <<< 24) + (96'(lh_ff) <<< 24)
               + $signed({48'b0, ll_ff});
   assign fl   = full[95:32];

   always_comb begin
      if (fl > 64'(Q_MAX)) begin
         prod = Q_MAX;
      end else if (fl < 64'(Q_MIN)) begin
         prod = Q_MIN;
      end else begin
         prod = fl[47:0];
      end
   end

endmodule

/* rtl/core/cpck_front.sv */
// front end: accepts pairs, picks the formula kind and queues the work for the back end
module cpck_front
   import cpck_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         push,
   output logic         full,
   input  req_word_type req_data,
   output logic         wk_valid,
   output work_type     wk_data,
   input  logic         wk_pop
);

   work_type   queue_ff [MID_DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       accept, in_on, in_off;
   kind_type   kind;
   work_type   entry;

   assign in_on  = req_data.dist_sq <= cfg.cut_on_sq;
   assign in_off = req_data.dist_sq <= cfg.cut_off_sq;

   always_comb begin
      kind = KIND_ZERO;
      if (!req_data.is_one_four) begin
         case (norm_mode_type'(cfg.pair_modes[1:0]))
            NORM_SHIFT1: kind = KIND_SH1;
            NORM_SHIFT2: kind = KIND_SH2;
            NORM_SWITCH: kind = in_on ? KIND_UNSW : KIND_SW;
            default:     kind = KIND_ZERO;
         endcase
      end else begin
         case (o14_mode_type'(cfg.pair_modes[4:2]))
            O14_FULL:   kind = KIND_UNSW;
            O14_SHIFT1: kind = in_off ? KIND_SH1 : KIND_ZERO;
            O14_SHIFT2: kind = in_off ? KIND_SH2 : KIND_ZERO;
            O14_SWITCH: kind = !in_off ? KIND_ZERO : (in_on ? KIND_UNSW : KIND_SW);
            default:    kind = KIND_ZERO;
         endcase
      end
   end

   assign entry.kind     = kind;
   assign entry.one_four = req_data.is_one_four;
   assign entry.q        = req_data.charge_product;
   assign entry.r2       = req_data.dist_sq;
   assign entry.rt       = req_data.inv_dist;

   assign full     = cnt_ff == 3'(MID_DEPTH);
   assign accept   = push && !full;
   assign wk_valid = cnt_ff != 3'd0;
   assign wk_data  = queue_ff[rd_ptr_ff];

   assign wr_ptr_in = accept ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
   assign rd_ptr_in = wk_pop ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
   assign cnt_in    = cnt_ff + 3'(accept) - 3'(wk_pop);

   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

/* rtl/core/cpck_back.sv */
// back end: pipelined energy and force evaluation with a credit-checked result queue
module cpck_back
   import cpck_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         wk_valid,
   input  work_type     wk_data,
   output logic         wk_pop,
   output logic         empty,
   input  logic         pop,
   output rsp_word_type rsp_data
);

   typedef struct packed {
      kind_type kind;
      logic     one_four;
      q_type    q, r2, rt;
      q_type    w, r2x12, u, v;
      q_type    x1, t1, s, ww, z1;
      q_type    x2, a1, bb, f1, z2;
      q_type    a2, bma, bsel, fsh, dsh;
      q_type    p, fsw, dsw, f, fd;
      q_type    e, prt, g;
   } carry_type;

   carry_type           carry_ff [PIPE_DEPTH];
   carry_type           carry_in [PIPE_DEPTH];
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   q_type               mul_a [MUL_COUNT];
   q_type               mul_b [MUL_COUNT];
   q_type               mul_p [MUL_COUNT];

   rsp_word_type oq_ff [OUT_DEPTH];
   logic [3:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [4:0]   ocnt_ff, ocnt_in;
   logic [3:0]   inflight;
   logic         oq_wr, oq_rd;
   rsp_word_type result;
   carry_type    last;

   for (genvar i = 0; i < MUL_COUNT; i++) begin : g_mul
      cpck_mul u_mul (
         .clock (clock),
         .op_a  (mul_a[i]),
         .op_b  (mul_b[i]),
         .prod  (mul_p[i])
      );
   end

   assign inflight = 4'($countones(vld_ff));
   assign wk_pop   = wk_valid && ((6'(ocnt_ff) + 6'(inflight)) < 6'(OUT_DEPTH));

   always_comb begin
      // multiplier operands, by level
      mul_a[0]  = carry_ff[1].one_four ? cfg.scale_one_four : cfg.charge_constant;
      mul_b[0]  = carry_ff[1].one_four ? cfg.charge_constant : carry_ff[1].q;
      mul_a[1]  = carry_ff[1].rt;
      mul_b[1]  = carry_ff[1].r2;
      mul_a[2]  = carry_ff[1].r2;
      mul_b[2]  = q_ext(cfg.inv_cutoff_sq);
      mul_a[3]  = carry_ff[1].w;
      mul_b[3]  = carry_ff[1].w;
      mul_a[4]  = carry_ff[1].r2x12;
      mul_b[4]  = carry_ff[1].w;
      mul_a[5]  = carry_ff[3].x1;
      mul_b[5]  = carry_ff[3].q;
      mul_a[6]  = carry_ff[3].t1;
      mul_b[6]  = q_ext(cfg.inv_cutoff);
      mul_a[7]  = carry_ff[3].s;
      mul_b[7]  = carry_ff[3].s;
      mul_a[8]  = carry_ff[3].ww;
      mul_b[8]  = carry_ff[3].v;
      mul_a[9]  = carry_ff[3].z1;
      mul_b[9]  = carry_ff[3].u;
      mul_a[10] = carry_ff[5].x2;
      mul_b[10] = carry_ff[5].rt;
      mul_a[11] = carry_ff[5].f1;
      mul_b[11] = cfg.switch_norm;
      mul_a[12] = carry_ff[5].z2;
      mul_b[12] = cfg.switch_norm;
      mul_a[13] = carry_ff[8].p;
      mul_b[13] = carry_ff[8].f;
      mul_a[14] = carry_ff[8].p;
      mul_b[14] = carry_ff[8].rt;
      mul_a[15] = carry_ff[10].prt;
      mul_b[15] = carry_ff[10].fd;
   end

   always_comb begin
      carry_in[0]          = '0;
      carry_in[0].kind     = wk_data.kind;
      carry_in[0].one_four = wk_data.one_four;
      carry_in[0].q        = wk_data.q;
      carry_in[0].r2       = q_ext(wk_data.r2);
      carry_in[0].rt       = q_ext(wk_data.rt);
      for (int k = 1; k < PIPE_DEPTH; k++) begin
         carry_in[k] = carry_ff[k-1];
      end

      // cutoff polynomial terms
      carry_in[1].w     = q_sub(q_ext(cfg.cut_off_sq), carry_ff[0].r2);
      carry_in[1].r2x12 = q_scale(carry_ff[0].r2, 4'd12);
      carry_in[1].u     = q_sub(q_ext(cfg.cut_on_sq), carry_ff[0].r2);
      carry_in[1].v     = q_sub(q_add(q_ext(cfg.cut_off_sq), q_scale(carry_ff[0].r2, 4'd2)),
                                q_scale(q_ext(cfg.cut_on_sq), 4'd3));

      carry_in[3].x1 = mul_p[0];
      carry_in[3].t1 = mul_p[1];
      carry_in[3].s  = mul_p[2];
      carry_in[3].ww = mul_p[3];
      carry_in[3].z1 = mul_p[4];

      carry_in[5].x2 = carry_ff[4].one_four ? mul_p[5] : carry_ff[4].x1;
      carry_in[5].a1 = mul_p[6];
      carry_in[5].bb = mul_p[7];
      carry_in[5].f1 = mul_p[8];
      carry_in[5].z2 = mul_p[9];

      // shifted and switched forms
      if (carry_ff[5].kind == KIND_SH1) begin
         carry_in[6].a2   = q_scale(carry_ff[5].a1, 4'd2);
         carry_in[6].bma  = q_sub(carry_ff[5].s, carry_ff[5].a1);
         carry_in[6].bsel = carry_ff[5].s;
      end else begin
         carry_in[6].a2   = q_scale(carry_ff[5].s, 4'd2);
         carry_in[6].bma  = q_sub(carry_ff[5].bb, carry_ff[5].s);
         carry_in[6].bsel = carry_ff[5].bb;
      end
      carry_in[7].fsh = q_add(q_sub(Q_ONE, carry_ff[6].a2), carry_ff[6].bsel);
      carry_in[7].dsh = q_scale(carry_ff[6].bma,
                                (carry_ff[6].kind == KIND_SH1) ? 4'd2 : 4'd4);
      carry_in[7].p   = mul_p[10];
      carry_in[7].fsw = mul_p[11];
      carry_in[7].dsw = mul_p[12];

      if (carry_ff[7].kind == KIND_SW) begin
         carry_in[8].f  = carry_ff[7].fsw;
         carry_in[8].fd = q_sub(carry_ff[7].dsw, carry_ff[7].fsw);
      end else begin
         carry_in[8].f  = carry_ff[7].fsh;
         carry_in[8].fd = q_sub(carry_ff[7].dsh, carry_ff[7].fsh);
      end

      carry_in[10].e   = mul_p[13];
      carry_in[10].prt = mul_p[14];
      carry_in[12].g   = mul_p[15];
   end

   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], wk_pop};

   always_ff @(posedge clock) begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
         carry_ff[k] <= carry_in[k];
      end
   end

   assign last = carry_ff[PIPE_DEPTH-1];

   always_comb begin
      case (last.kind)
         KIND_UNSW: begin
            result.energy       = last.p;
            result.force_factor = q_neg(last.prt);
         end
         KIND_SH1, KIND_SH2, KIND_SW: begin
            result.energy       = last.e;
            result.force_factor = last.g;
         end
         default: begin
            result.energy       = '0;
            result.force_factor = '0;
         end
      endcase
   end

   assign oq_wr     = vld_ff[PIPE_DEPTH-1];
   assign empty     = ocnt_ff == 5'd0;
   assign oq_rd     = pop && !empty;
   assign rsp_data  = oq_ff[rd_ptr_ff];
   assign wr_ptr_in = oq_wr ? wr_ptr_ff + 4'd1 : wr_ptr_ff;
   assign rd_ptr_in = oq_rd ? rd_ptr_ff + 4'd1 : rd_ptr_ff;
   assign ocnt_in   = ocnt_ff + 5'(oq_wr) - 5'(oq_rd);

   always_ff @(posedge clock) begin
      if (oq_wr) begin
         oq_ff[wr_ptr_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         ocnt_ff   <= '0;
      end else begin
         vld_ff    <= vld_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         ocnt_ff   <= ocnt_in;
      end
   end

endmodule

/* rtl/core/coulomb_pair_cutoff_kernel_top.sv */
// top level of the coulomb pair kernel: register port, front end and back end
//
//   channel   ports                                   word
//   request   push, full, req_data                    req_word_type
//   result    empty, pop, rsp_data                    rsp_word_type
//   config    psel, penable, pwrite, paddr, pwdata,   64-bit registers at 8*index
//             prdata, pready
//
// one pair is taken every cycle while full is low; a result reaches the result ports after its request
// word passes the 4-entry request queue, the 13-stage evaluation pipeline and the 16-entry result queue.
// the back end only pulls a word when the result queue has room for everything in flight.
// reset is synchronous; it clears the config registers to zero and empties both queues.
// a stalled consumer fills the result queue, then the request queue, then raises full.
module coulomb_pair_cutoff_kernel_top
   import cpck_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  req_word_type req_data,
   output logic         empty,
   input  logic         pop,
   output rsp_word_type rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [5:0]   paddr,
   input  logic [63:0]  pwdata,
   output logic [63:0]  prdata,
   output logic         pready
);

   cfg_type       cfg_ff, cfg_in;
   logic          csr_wr;
   reg_index_type csr_idx;
   logic          wk_valid, wk_pop;
   work_type      wk_data;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = reg_index_type'(paddr[5:3]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_PAIR_MODES:      cfg_in.pair_modes      = pwdata[4:0];
            REG_CHARGE_CONSTANT: cfg_in.charge_constant = pwdata[47:0];
            REG_SCALE_ONE_FOUR:  cfg_in.scale_one_four  = pwdata[47:0];
            REG_INV_CUTOFF:      cfg_in.inv_cutoff      = pwdata[46:0];
            REG_INV_CUTOFF_SQ:   cfg_in.inv_cutoff_sq   = pwdata[46:0];
            REG_CUT_ON_SQ:       cfg_in.cut_on_sq       = pwdata[46:0];
            REG_CUT_OFF_SQ:      cfg_in.cut_off_sq      = pwdata[46:0];
            REG_SWITCH_NORM:     cfg_in.switch_norm     = pwdata[47:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_PAIR_MODES:      prdata = 64'(cfg_ff.pair_modes);
         REG_CHARGE_CONSTANT: prdata = 64'(cfg_ff.charge_constant);
         REG_SCALE_ONE_FOUR:  prdata = 64'(cfg_ff.scale_one_four);
         REG_INV_CUTOFF:      prdata = 64'(cfg_ff.inv_cutoff);
         REG_INV_CUTOFF_SQ:   prdata = 64'(cfg_ff.inv_cutoff_sq);
         REG_CUT_ON_SQ:       prdata = 64'(cfg_ff.cut_on_sq);
         REG_CUT_OFF_SQ:      prdata = 64'(cfg_ff.cut_off_sq);
         REG_SWITCH_NORM:     prdata = 64'(cfg_ff.switch_norm);
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cpck_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .wk_valid (wk_valid),
      .wk_data  (wk_data),
      .wk_pop   (wk_pop)
   );

   cpck_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .wk_valid (wk_valid),
      .wk_data  (wk_data),
      .wk_pop   (wk_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule
